// ----- src/scd_pkg.sv -----
`default_nettype none

package scd_pkg;

   // Width of the seconds count that takes part in the conversion.
   localparam int SECONDS_WIDTH = 32;

   // Derived widths. A day has more than 2^16 seconds, so the whole-day count
   // fits in SECONDS_WIDTH - 16 bits. The other widths follow from that bound.
   localparam int DAYS_W = SECONDS_WIDTH - 16;
   localparam int N400_W = SECONDS_WIDTH - 31;
   localparam int YOFF_W = SECONDS_WIDTH - 21;
   localparam int PROD_W = 2 * SECONDS_WIDTH;
   localparam int REM_W  = 18;
   localparam int SOD_W  = 17;

   // Calendar constants.
   localparam int BASE_YEAR       = 1900;
   localparam int ERA_START_YEAR  = 1601;
   localparam int DAYS_PER_YEAR   = 365;
   localparam int YEARS_PER_ERA   = 400;
   localparam int YEARS_PER_CENT  = 100;
   localparam int YEARS_PER_QUAD  = 4;
   localparam int DAYS_PER_CENT   = 36524;
   localparam int DAYS_1601_1900  = 109207;

   // Divisors handled by the shared constant divider.
   localparam int DIVISOR_DAY  = 86400;
   localparam int DIVISOR_ERA  = 146097;
   localparam int DIVISOR_HOUR = 3600;
   localparam int DIVISOR_QUAD = 1461;
   localparam int DIVISOR_MIN  = 60;

   // Truncated reciprocals: floor(2^SECONDS_WIDTH / divisor). The estimate they
   // give is low by at most one for any dividend below 2^SECONDS_WIDTH.
   localparam logic [SECONDS_WIDTH-1:0] RECIP_DAY =
      SECONDS_WIDTH'((64'd1 << SECONDS_WIDTH) / 64'd86400);
   localparam logic [SECONDS_WIDTH-1:0] RECIP_ERA =
      SECONDS_WIDTH'((64'd1 << SECONDS_WIDTH) / 64'd146097);
   localparam logic [SECONDS_WIDTH-1:0] RECIP_HOUR =
      SECONDS_WIDTH'((64'd1 << SECONDS_WIDTH) / 64'd3600);
   localparam logic [SECONDS_WIDTH-1:0] RECIP_QUAD =
      SECONDS_WIDTH'((64'd1 << SECONDS_WIDTH) / 64'd1461);
   localparam logic [SECONDS_WIDTH-1:0] RECIP_MIN =
      SECONDS_WIDTH'((64'd1 << SECONDS_WIDTH) / 64'd60);

   // Day of year at the first of each month, common year then leap year.
   typedef logic [8:0] doy_type;
   localparam doy_type MONTH_START [0:1][0:11] = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
   };

   // Operation issued to the constant divider.
   typedef enum logic [2:0] {
      DIV_NONE,
      DIV_DAY,
      DIV_ERA,
      DIV_HOUR,
      DIV_QUAD,
      DIV_MIN
   } div_op_type;

   // Date step done by the compare logic.
   typedef enum logic [1:0] {
      DATE_NONE,
      DATE_CENT,
      DATE_YEAR,
      DATE_MONTH
   } date_op_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAY,
      ST_DAY_WAIT,
      ST_ERA,
      ST_HOUR,
      ST_CENT,
      ST_QUAD,
      ST_MIN,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      div_op_type  div_op;
      date_op_type date_op;
   } cmd_type;

   // Divisor for a divider operation.
   function automatic logic [SECONDS_WIDTH-1:0] div_divisor(input div_op_type op);
      logic [SECONDS_WIDTH-1:0] d;
      unique case (op)
         DIV_DAY:  d = SECONDS_WIDTH'(DIVISOR_DAY);
         DIV_ERA:  d = SECONDS_WIDTH'(DIVISOR_ERA);
         DIV_HOUR: d = SECONDS_WIDTH'(DIVISOR_HOUR);
         DIV_QUAD: d = SECONDS_WIDTH'(DIVISOR_QUAD);
         DIV_MIN:  d = SECONDS_WIDTH'(DIVISOR_MIN);
         default:  d = SECONDS_WIDTH'(1);
      endcase
      return d;
   endfunction

   // Reciprocal for a divider operation.
   function automatic logic [SECONDS_WIDTH-1:0] div_recip(input div_op_type op);
      logic [SECONDS_WIDTH-1:0] r;
      unique case (op)
         DIV_DAY:  r = RECIP_DAY;
         DIV_ERA:  r = RECIP_ERA;
         DIV_HOUR: r = RECIP_HOUR;
         DIV_QUAD: r = RECIP_QUAD;
         DIV_MIN:  r = RECIP_MIN;
         default:  r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/scd_cdiv.sv -----
`default_nettype none

module scd_cdiv
   import scd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire div_op_type               issue_op,
   input  wire logic [SECONDS_WIDTH-1:0] issue_x,
   output div_op_type                    res_op,
   output logic [SECONDS_WIDTH-1:0]      res_quo,
   output logic [REM_W-1:0]              res_rem
);

   div_op_type               op_ff;
   logic [SECONDS_WIDTH-1:0] x_ff;
   logic [SECONDS_WIDTH-1:0] q_ff;
   logic [PROD_W-1:0]        product;
   logic [SECONDS_WIDTH-1:0] divisor;
   logic [SECONDS_WIDTH-1:0] back;
   logic [SECONDS_WIDTH-1:0] part;
   logic [SECONDS_WIDTH-1:0] part_fixed;
   logic                     fix;

   // First stage: quotient estimate from the reciprocal product.
   assign product = PROD_W'(issue_x) * PROD_W'(div_recip(issue_op));

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= DIV_NONE;
      end else begin
         op_ff <= issue_op;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= issue_x;
      q_ff <= product[PROD_W-1:SECONDS_WIDTH];
   end

   // Second stage: remainder, and one correction when the estimate was low.
   always_comb begin
      divisor    = div_divisor(op_ff);
      back       = q_ff * divisor;
      part       = x_ff - back;
      fix        = (part >= divisor);
      part_fixed = fix ? (part - divisor) : part;
   end

   assign res_op  = op_ff;
   assign res_quo = q_ff + SECONDS_WIDTH'(fix);
   assign res_rem = part_fixed[REM_W-1:0];

   // A single correction must bring the remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (res_op != DIV_NONE) |-> (part_fixed < divisor))
      else $error("constant divider remainder out of range");

endmodule

`default_nettype wire

// ----- src/scd_dpath.sv -----
`default_nettype none

module scd_dpath
   import scd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic [SECONDS_WIDTH-1:0] req_seconds,
   output logic [7:0]                    years_since_1900,
   output logic [3:0]                    month,
   output logic [4:0]                    day_of_month,
   output logic [4:0]                    hour,
   output logic [5:0]                    minute,
   output logic [5:0]                    second
);

   logic [SECONDS_WIDTH-1:0] secs_ff;
   logic [DAYS_W-1:0]        days_ff;
   logic [SOD_W-1:0]         sod_ff;
   logic [N400_W-1:0]        n400_ff;
   logic [REM_W-1:0]         d1_ff;
   logic [4:0]               hour_ff;
   logic [11:0]              rem2_ff;
   logic [1:0]               n100_ff;
   logic [15:0]              d2_ff;
   logic [4:0]               n4_ff;
   logic [10:0]              d3_ff;
   logic [5:0]               minute_ff;
   logic [5:0]               second_ff;
   logic [YOFF_W-1:0]        yoff_ff;
   logic [8:0]               d4_ff;
   logic                     leap_ff;
   logic [3:0]               month_ff;
   logic [4:0]               mday_ff;

   logic [1:0]               n100_in;
   logic [REM_W-1:0]         cent_days;
   logic [15:0]              d2_in;
   logic [1:0]               n1_in;
   logic [10:0]              year_days;
   logic [8:0]               d4_in;
   logic                     leap_in;
   logic [YOFF_W-1:0]        yoff_in;
   logic [3:0]               month_in;
   logic [4:0]               mday_in;
   logic [YOFF_W-1:0]        year_diff;

   logic [SECONDS_WIDTH-1:0] div_x;
   div_op_type               res_op;
   logic [SECONDS_WIDTH-1:0] res_quo;
   logic [REM_W-1:0]         res_rem;

   // Capture the request.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         secs_ff <= req_seconds;
      end
   end

   // Operand for the divider.
   always_comb begin
      unique case (cmd.div_op)
         DIV_DAY:  div_x = secs_ff;
         DIV_ERA:  div_x = SECONDS_WIDTH'(days_ff) + SECONDS_WIDTH'(DAYS_1601_1900);
         DIV_HOUR: div_x = SECONDS_WIDTH'(sod_ff);
         DIV_QUAD: div_x = SECONDS_WIDTH'(d2_ff);
         DIV_MIN:  div_x = SECONDS_WIDTH'(rem2_ff);
         default:  div_x = '0;
      endcase
   end

   scd_cdiv u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .issue_op (cmd.div_op),
      .issue_x  (div_x),
      .res_op   (res_op),
      .res_quo  (res_quo),
      .res_rem  (res_rem)
   );

   // Centuries within the 400-year era; the last century has one extra day.
   always_comb begin
      n100_in   = 2'({1'b0, d1_ff >= REM_W'(DAYS_PER_CENT)}
                   + {1'b0, d1_ff >= REM_W'(2 * DAYS_PER_CENT)}
                   + {1'b0, d1_ff >= REM_W'(3 * DAYS_PER_CENT)});
      cent_days = REM_W'(n100_in) * REM_W'(DAYS_PER_CENT);
      d2_in     = 16'(d1_ff - cent_days);
   end

   // Years within the four-year group, leap flag and year offset from 1601.
   always_comb begin
      n1_in     = 2'({1'b0, d3_ff >= 11'(DAYS_PER_YEAR)}
                   + {1'b0, d3_ff >= 11'(2 * DAYS_PER_YEAR)}
                   + {1'b0, d3_ff >= 11'(3 * DAYS_PER_YEAR)});
      year_days = 11'(n1_in) * 11'(DAYS_PER_YEAR);
      d4_in     = 9'(d3_ff - year_days);
      leap_in   = (n1_in == 2'd3) && ((n4_ff != 5'd24) || (n100_ff == 2'd3));
      yoff_in   = YOFF_W'(n400_ff) * YOFF_W'(YEARS_PER_ERA)
                + YOFF_W'(n100_ff) * YOFF_W'(YEARS_PER_CENT)
                + YOFF_W'(n4_ff) * YOFF_W'(YEARS_PER_QUAD)
                + YOFF_W'(n1_in);
   end

   // Month by comparing the day of year against every month start after January.
   always_comb begin
      month_in = '0;
      for (int m = 1; m < 12; m++) begin
         if (d4_ff >= MONTH_START[leap_ff][m]) begin
            month_in = 4'(m);
         end
      end
      mday_in = 5'(d4_ff - MONTH_START[leap_ff][month_in] + 9'd1);
   end

   // Results returned by the divider, routed by their operation tag.
   always_ff @(posedge clock) begin
      case (res_op)
         DIV_DAY: begin
            days_ff <= res_quo[DAYS_W-1:0];
            sod_ff  <= res_rem[SOD_W-1:0];
         end
         DIV_ERA: begin
            n400_ff <= res_quo[N400_W-1:0];
            d1_ff   <= res_rem;
         end
         DIV_HOUR: begin
            hour_ff <= res_quo[4:0];
            rem2_ff <= res_rem[11:0];
         end
         DIV_QUAD: begin
            n4_ff <= res_quo[4:0];
            d3_ff <= res_rem[10:0];
         end
         DIV_MIN: begin
            minute_ff <= res_quo[5:0];
            second_ff <= res_rem[5:0];
         end
         default: begin
         end
      endcase
   end

   // Date steps.
   always_ff @(posedge clock) begin
      case (cmd.date_op)
         DATE_CENT: begin
            n100_ff <= n100_in;
            d2_ff   <= d2_in;
         end
         DATE_YEAR: begin
            d4_ff   <= d4_in;
            leap_ff <= leap_in;
            yoff_ff <= yoff_in;
         end
         DATE_MONTH: begin
            month_ff <= month_in;
            mday_ff  <= mday_in;
         end
         default: begin
         end
      endcase
   end

   assign year_diff        = yoff_ff - YOFF_W'(BASE_YEAR - ERA_START_YEAR);
   assign years_since_1900 = year_diff[7:0];
   assign month            = month_ff;
   assign day_of_month     = mday_ff;
   assign hour             = hour_ff;
   assign minute           = minute_ff;
   assign second           = second_ff;

   // The day of year must lie inside the year it was found in.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.date_op == DATE_MONTH) |-> ((d4_ff < 9'(DAYS_PER_YEAR))
         || (leap_ff && (d4_ff == 9'(DAYS_PER_YEAR)))))
      else $error("day of year outside its year");

endmodule

`default_nettype wire

// ----- src/scd_ctrl.sv -----
`default_nettype none

module scd_ctrl
   import scd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output logic      rsp_strobe,
   output cmd_type   cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a fixed schedule of divider issues and date steps.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:     state_in = start ? ST_DAY : ST_IDLE;
         ST_DAY:      state_in = ST_DAY_WAIT;
         ST_DAY_WAIT: state_in = ST_ERA;
         ST_ERA:      state_in = ST_HOUR;
         ST_HOUR:     state_in = ST_CENT;
         ST_CENT:     state_in = ST_QUAD;
         ST_QUAD:     state_in = ST_MIN;
         ST_MIN:      state_in = ST_YEAR;
         ST_YEAR:     state_in = ST_MONTH;
         ST_MONTH:    state_in = ST_DONE;
         ST_DONE:     state_in = start ? ST_DAY : ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs for each state. A request is loaded in the states where busy is low.
   always_comb begin
      busy         = 1'b1;
      rsp_strobe   = 1'b0;
      cmd.load     = 1'b0;
      cmd.div_op   = DIV_NONE;
      cmd.date_op  = DATE_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DAY:   cmd.div_op = DIV_DAY;
         ST_ERA:   cmd.div_op = DIV_ERA;
         ST_HOUR:  cmd.div_op = DIV_HOUR;
         ST_CENT:  cmd.date_op = DATE_CENT;
         ST_QUAD:  cmd.div_op = DIV_QUAD;
         ST_MIN:   cmd.div_op = DIV_MIN;
         ST_YEAR:  cmd.date_op = DATE_YEAR;
         ST_MONTH: cmd.date_op = DATE_MONTH;
         ST_DONE: begin
            busy       = 1'b0;
            rsp_strobe = 1'b1;
            cmd.load   = start;
         end
         default: begin
         end
      endcase
   end

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted request");

   // The result strobe lasts one cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // Every result follows an accepted request through the full state sequence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 10))
      else $error("result without a request ten cycles before");

endmodule

`default_nettype wire

// ----- src/seconds_to_calendar_date.sv -----
// Converts a count of seconds since 1900-01-01 00:00:00 UTC into the
// Gregorian date (years since 1900, month 0-11, day 1-31) and time of day.
// A request is taken at a rising edge where start is high and busy is low;
// req_seconds is sampled then. The result appears on the rsp_ ports with
// rsp_strobe high for exactly one cycle, when the controller reaches its
// done state. busy is low in that strobe cycle, so a new request may be
// accepted there; busy is high in all states in between.
// A conversion runs a chain of five divisions by constants (seconds per
// day, days per 400 years, seconds per hour, days per four years, seconds
// per minute), each through one shared reciprocal-multiply unit with a
// single correction step, plus three compare steps for centuries, years
// and months.
// The receiver cannot stall: a result is valid only in its strobe cycle.
// The result ports keep their value until the next request overwrites them.
// Reset is synchronous and returns the controller to idle; a request in
// flight is dropped and gives no result.
`default_nettype none

module seconds_to_calendar_date
   import scd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [SECONDS_WIDTH-1:0] req_seconds,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_years_since_1900,
   output logic [3:0]                    rsp_month,
   output logic [4:0]                    rsp_day_of_month,
   output logic [4:0]                    rsp_hour,
   output logic [5:0]                    rsp_minute,
   output logic [5:0]                    rsp_second
);

   cmd_type cmd;

   // Sequencer.
   scd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Arithmetic and result registers.
   scd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_seconds      (req_seconds),
      .years_since_1900 (rsp_years_since_1900),
      .month            (rsp_month),
      .day_of_month     (rsp_day_of_month),
      .hour             (rsp_hour),
      .minute           (rsp_minute),
      .second           (rsp_second)
   );

endmodule

`default_nettype wire
